// File: design/sgr_attribute_interpreter_macros.svh
// Assertion helpers for the checker of the SGR attribute interpreter.
`ifndef SGR_ATTRIBUTE_INTERPRETER_MACROS_SVH
`define SGR_ATTRIBUTE_INTERPRETER_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define SGR_AI_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define SGR_AI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/sgr_ai_pkg.sv
package sgr_ai_pkg;

  localparam int unsigned PARAM_W = 16;
  localparam int unsigned RGB_W   = 24;
  localparam int unsigned CHAN_W  = 8;

  typedef logic [PARAM_W-1:0] param_t;
  typedef logic [RGB_W-1:0]   rgb_t;
  typedef logic [CHAN_W-1:0]  chan_t;

  // Attribute set held between requests.
  typedef struct packed {
    logic bold;
    logic italic;
    logic underline;
    logic reverse_video;
    logic strikethrough;
    logic fg_valid;
    rgb_t fg_rgb;
    logic bg_valid;
    rgb_t bg_rgb;
  } attr_t;

  // SGR codes
  localparam param_t SGR_RESET       = 16'd0;
  localparam param_t SGR_BOLD        = 16'd1;
  localparam param_t SGR_ITALIC      = 16'd3;
  localparam param_t SGR_UNDERLINE   = 16'd4;
  localparam param_t SGR_REVERSE     = 16'd7;
  localparam param_t SGR_STRIKE      = 16'd9;
  localparam param_t SGR_NO_BOLD     = 16'd22;
  localparam param_t SGR_NO_ITALIC   = 16'd23;
  localparam param_t SGR_NO_UNDER    = 16'd24;
  localparam param_t SGR_NO_REVERSE  = 16'd27;
  localparam param_t SGR_NO_STRIKE   = 16'd29;
  localparam param_t SGR_FG_BASE     = 16'd30;
  localparam param_t SGR_FG_EXT      = 16'd38;
  localparam param_t SGR_FG_DEFAULT  = 16'd39;
  localparam param_t SGR_BG_BASE     = 16'd40;
  localparam param_t SGR_BG_EXT      = 16'd48;
  localparam param_t SGR_BG_DEFAULT  = 16'd49;
  localparam param_t SGR_FG_BRIGHT   = 16'd90;
  localparam param_t SGR_BG_BRIGHT   = 16'd100;
  localparam param_t SGR_SEL_RGB     = 16'd2;
  localparam param_t SGR_SEL_INDEX   = 16'd5;
  localparam param_t SGR_COLOR_SPAN  = 16'd7;

  // Fixed 16-entry palette, channels already rounded to 8 bits.
  localparam rgb_t PAL16 [16] = '{
    24'h0D0F12, 24'hCC3D3D, 24'h66BA6B, 24'hE0BA4D,
    24'h4A82D1, 24'hB369C7, 24'h47BACC, 24'hD6D6D9,
    24'h545759, 24'hF06161, 24'h7DD18A, 24'hF5D170,
    24'h75A6ED, 24'hCF8CE0, 24'h7ADBED, 24'hF7FAFA
  };

  localparam chan_t CUBE_LEVEL [6] = '{8'd0, 8'd95, 8'd135, 8'd175, 8'd215, 8'd255};

  function automatic chan_t sgr_clamp8(param_t v);
    return (v > param_t'(8'hFF)) ? 8'hFF : v[CHAN_W-1:0];
  endfunction

  function automatic logic in_span(param_t v, param_t base);
    return (v >= base) && (v <= base + SGR_COLOR_SPAN);
  endfunction

  // Apply one ordinary code to an attribute set.
  function automatic attr_t sgr_apply(attr_t a, param_t v);
    attr_t  r;
    param_t off;
    r   = a;
    off = '0;
    unique case (v)
      SGR_RESET:      r = '0;
      SGR_BOLD:       r.bold = 1'b1;
      SGR_ITALIC:     r.italic = 1'b1;
      SGR_UNDERLINE:  r.underline = 1'b1;
      SGR_REVERSE:    r.reverse_video = 1'b1;
      SGR_STRIKE:     r.strikethrough = 1'b1;
      SGR_NO_BOLD:    r.bold = 1'b0;
      SGR_NO_ITALIC:  r.italic = 1'b0;
      SGR_NO_UNDER:   r.underline = 1'b0;
      SGR_NO_REVERSE: r.reverse_video = 1'b0;
      SGR_NO_STRIKE:  r.strikethrough = 1'b0;
      SGR_FG_DEFAULT: r.fg_valid = 1'b0;
      SGR_BG_DEFAULT: r.bg_valid = 1'b0;
      default: begin
        if (in_span(v, SGR_FG_BASE)) begin
          off        = v - SGR_FG_BASE;
          r.fg_valid = 1'b1;
          r.fg_rgb   = PAL16[{1'b0, off[2:0]}];
        end else if (in_span(v, SGR_BG_BASE)) begin
          off        = v - SGR_BG_BASE;
          r.bg_valid = 1'b1;
          r.bg_rgb   = PAL16[{1'b0, off[2:0]}];
        end else if (in_span(v, SGR_FG_BRIGHT)) begin
          off        = v - SGR_FG_BRIGHT;
          r.fg_valid = 1'b1;
          r.fg_rgb   = PAL16[{1'b1, off[2:0]}];
        end else if (in_span(v, SGR_BG_BRIGHT)) begin
          off        = v - SGR_BG_BRIGHT;
          r.bg_valid = 1'b1;
          r.bg_rgb   = PAL16[{1'b1, off[2:0]}];
        end
      end
    endcase
    return r;
  endfunction

endpackage

// File: design/sgr_ai_if.sv
interface sgr_ai_req_if import sgr_ai_pkg::*; ;
  logic   valid;
  logic   ready;
  param_t param_value;
  logic   last_param;
  logic   list_is_empty;

  modport source (output valid, param_value, last_param, list_is_empty, input ready);
  modport sink (input valid, param_value, last_param, list_is_empty, output ready);
endinterface

interface sgr_ai_rsp_if import sgr_ai_pkg::*; ;
  logic valid;
  logic ready;
  logic bold;
  logic italic;
  logic underline;
  logic reverse_video;
  logic strikethrough;
  logic fg_valid;
  rgb_t fg_rgb;
  logic bg_valid;
  rgb_t bg_rgb;
  logic sequence_done;

  modport source (output valid, bold, italic, underline, reverse_video, strikethrough,
                  fg_valid, fg_rgb, bg_valid, bg_rgb, sequence_done, input ready);
  modport sink (input valid, bold, italic, underline, reverse_video, strikethrough,
                fg_valid, fg_rgb, bg_valid, bg_rgb, sequence_done, output ready);
endinterface

// File: design/sgr_ai_xterm.sv
module sgr_ai_xterm import sgr_ai_pkg::*; (
  input  chan_t idx_i,
  output rgb_t  rgb_o
);

  chan_t       cube_idx;
  logic [13:0] prod36;
  logic [2:0]  dig_r;
  chan_t       rem_full;
  logic [5:0]  rem36;
  logic [10:0] prod6;
  logic [2:0]  dig_g;
  logic [5:0]  rem6;
  chan_t       gray_step;
  chan_t       gray;

  // Base-6 digits of the cube offset via reciprocal multiplies (offset < 216).
  assign cube_idx  = idx_i - 8'd16;
  assign prod36    = 14'(cube_idx) * 14'd57;
  assign dig_r     = prod36[13:11];
  assign rem_full  = cube_idx - ({dig_r, 5'b0} + {3'b0, dig_r, 2'b0});
  assign rem36     = rem_full[5:0];
  assign prod6     = 11'(rem36) * 11'd43;
  assign dig_g     = prod6[10:8];
  assign rem6      = rem36 - ({1'b0, dig_g, 2'b0} + {2'b0, dig_g, 1'b0});

  assign gray_step = idx_i - 8'd232;
  assign gray      = 8'(gray_step * 8'd10) + 8'd8;

  always_comb begin
    if (idx_i < 8'd16) begin
      rgb_o = PAL16[idx_i[3:0]];
    end else if (idx_i <= 8'd231) begin
      rgb_o = {CUBE_LEVEL[dig_r], CUBE_LEVEL[dig_g], CUBE_LEVEL[rem6[2:0]]};
    end else begin
      rgb_o = {gray, gray, gray};
    end
  end

endmodule

// File: design/sgr_attribute_interpreter.sv
// SGR attribute interpreter.
//
// req_i carries the numeric parameters of one SGR escape sequence, one per
// request, with last_param marking the final one and list_is_empty standing
// for a sequence without parameters. Each request yields exactly one result
// on rsp_o: the text attribute set (flags, foreground, background) after
// that parameter, plus sequence_done. A color whose valid bit is low reads
// as zero.
//
// Each request passes through the input register, then through the decode
// into the output register. Throughput: one request per cycle while rsp_o
// is ready; the attribute state updates in the same cycle a request leaves
// the input register, so the next parameter sees it without a bubble.
//
// Reset clears the attributes, any pending 38/48 extended color and both
// pipeline stages. When rsp_o stalls, the output register holds its result
// and the input register still takes one more request; req_i.ready drops
// only when both stages are full.
module sgr_attribute_interpreter import sgr_ai_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  sgr_ai_req_if.sink    req_i,
  sgr_ai_rsp_if.source  rsp_o
);

  typedef enum logic [2:0] {
    PS_IDLE,
    PS_SEL,
    PS_IDX,
    PS_RED,
    PS_GREEN,
    PS_BLUE
  } pend_e;

  // Input register
  logic   s1_valid_q;
  param_t s1_value_q;
  logic   s1_last_q;
  logic   s1_empty_q;

  // Interpreter state
  pend_e  pend_q, pend_d;
  logic   to_fg_q, to_fg_d;
  param_t held_red_q, held_red_d;
  chan_t  held_green_q, held_green_d;
  attr_t  attr_q, attr_d;

  // Output register
  logic   out_valid_q;
  attr_t  out_attr_q;
  logic   out_done_q;

  logic   out_ready;
  logic   advance;
  attr_t  plain_attr;
  attr_t  red_attr;
  attr_t  tail_attr;
  logic   opens_ext;
  chan_t  xterm_idx;
  rgb_t   xterm_rgb;
  rgb_t   true_rgb;
  rgb_t   new_rgb;
  attr_t  shown;

  assign out_ready   = !out_valid_q || rsp_o.ready;
  assign advance     = s1_valid_q && out_ready;
  assign req_i.ready = !s1_valid_q || out_ready;

  // Ordinary code and the two-code replay of a cut-short true color.
  assign plain_attr = sgr_apply(attr_q, s1_value_q);
  assign red_attr   = sgr_apply(attr_q, held_red_q);
  assign tail_attr  = sgr_apply(red_attr, s1_value_q);
  assign opens_ext  = !s1_last_q && (s1_value_q == SGR_FG_EXT || s1_value_q == SGR_BG_EXT);

  assign xterm_idx  = sgr_clamp8(s1_value_q);
  assign true_rgb   = {sgr_clamp8(held_red_q), held_green_q, sgr_clamp8(s1_value_q)};
  assign new_rgb    = (pend_q == PS_IDX) ? xterm_rgb : true_rgb;

  sgr_ai_xterm u_xterm (
    .idx_i (xterm_idx),
    .rgb_o (xterm_rgb)
  );

  always_comb begin
    pend_d       = pend_q;
    to_fg_d      = to_fg_q;
    held_red_d   = held_red_q;
    held_green_d = held_green_q;
    attr_d       = attr_q;
    if (advance) begin
      pend_d = PS_IDLE;
      if (s1_empty_q) begin
        // Empty list: drop any pending form, act as a reset code.
        attr_d = '0;
      end else begin
        unique case (pend_q)
          PS_SEL: begin
            if (s1_value_q == SGR_SEL_INDEX && !s1_last_q) begin
              pend_d = PS_IDX;
            end else if (s1_value_q == SGR_SEL_RGB && !s1_last_q) begin
              pend_d = PS_RED;
            end else begin
              attr_d = plain_attr;
              if (opens_ext) begin
                pend_d  = PS_SEL;
                to_fg_d = (s1_value_q == SGR_FG_EXT);
              end
            end
          end
          PS_IDX, PS_BLUE: begin
            if (to_fg_q) begin
              attr_d.fg_valid = 1'b1;
              attr_d.fg_rgb   = new_rgb;
            end else begin
              attr_d.bg_valid = 1'b1;
              attr_d.bg_rgb   = new_rgb;
            end
          end
          PS_RED: begin
            if (s1_last_q) begin
              attr_d = plain_attr;
            end else begin
              held_red_d = s1_value_q;
              pend_d     = PS_GREEN;
            end
          end
          PS_GREEN: begin
            if (s1_last_q) begin
              attr_d = tail_attr;
            end else begin
              held_green_d = sgr_clamp8(s1_value_q);
              pend_d       = PS_BLUE;
            end
          end
          default: begin
            attr_d = plain_attr;
            if (opens_ext) begin
              pend_d  = PS_SEL;
              to_fg_d = (s1_value_q == SGR_FG_EXT);
            end
          end
        endcase
      end
    end
  end

  // Zero a color whose valid bit is low before it reaches the port.
  always_comb begin
    shown = attr_d;
    if (!attr_d.fg_valid) begin
      shown.fg_rgb = '0;
    end
    if (!attr_d.bg_valid) begin
      shown.bg_rgb = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      pend_q       <= PS_IDLE;
      to_fg_q      <= 1'b0;
      held_red_q   <= '0;
      held_green_q <= '0;
      attr_q       <= '0;
    end else begin
      if (req_i.ready) begin
        s1_valid_q <= req_i.valid;
      end
      if (out_ready) begin
        out_valid_q <= s1_valid_q;
      end
      pend_q       <= pend_d;
      to_fg_q      <= to_fg_d;
      held_red_q   <= held_red_d;
      held_green_q <= held_green_d;
      attr_q       <= attr_d;
    end
  end

  // Payload registers: load on accept or advance only.
  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      s1_value_q <= req_i.param_value;
      s1_last_q  <= req_i.last_param;
      s1_empty_q <= req_i.list_is_empty;
    end
    if (advance) begin
      out_attr_q <= shown;
      out_done_q <= s1_last_q || s1_empty_q;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.bold          = out_attr_q.bold;
  assign rsp_o.italic        = out_attr_q.italic;
  assign rsp_o.underline     = out_attr_q.underline;
  assign rsp_o.reverse_video = out_attr_q.reverse_video;
  assign rsp_o.strikethrough = out_attr_q.strikethrough;
  assign rsp_o.fg_valid      = out_attr_q.fg_valid;
  assign rsp_o.fg_rgb        = out_attr_q.fg_rgb;
  assign rsp_o.bg_valid      = out_attr_q.bg_valid;
  assign rsp_o.bg_rgb        = out_attr_q.bg_rgb;
  assign rsp_o.sequence_done = out_done_q;

endmodule

// File: design/sgr_ai_checker.sv
`include "sgr_attribute_interpreter_macros.svh"

module sgr_ai_checker import sgr_ai_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic req_ready_i,
  input logic rsp_valid_i,
  input logic rsp_ready_i,
  input logic bold_i,
  input logic fg_valid_i,
  input rgb_t fg_rgb_i,
  input logic bg_valid_i,
  input rgb_t bg_rgb_i,
  input logic done_i
);

  // An unset color never shows a value.
  `SGR_AI_ASSERT_ALWAYS(a_color_masked, !rsp_valid_i || ((fg_valid_i || fg_rgb_i == '0) && (bg_valid_i || bg_rgb_i == '0)), "color shown while its valid bit is low")

  // With the output register empty, the block must take a request.
  `SGR_AI_ASSERT_ALWAYS(a_ready_when_drained, rsp_valid_i || req_ready_i, "request refused while the output is empty")

  // A stalled result holds.
  `SGR_AI_ASSERT_NEXT(a_stall_hold, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(bold_i) && $stable(fg_rgb_i) && $stable(bg_rgb_i) && $stable(done_i), "stalled result changed")

endmodule

bind sgr_attribute_interpreter sgr_ai_checker u_sgr_ai_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .bold_i      (rsp_o.bold),
  .fg_valid_i  (rsp_o.fg_valid),
  .fg_rgb_i    (rsp_o.fg_rgb),
  .bg_valid_i  (rsp_o.bg_valid),
  .bg_rgb_i    (rsp_o.bg_rgb),
  .done_i      (rsp_o.sequence_done)
);

// File: test/sgr_attribute_interpreter_checker.sv
`timescale 1ns / 100ps

module sgr_attribute_interpreter_checker import sgr_ai_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  sgr_ai_req_if        req_i,
  sgr_ai_rsp_if        rsp_i,
  output int           fail_count_o,
  output int           outstanding_o
);

  typedef enum logic [2:0] {
    EXT_IDLE, EXT_SEL, EXT_IDX, EXT_RED, EXT_GREEN, EXT_BLUE
  } ext_step_e;

  typedef struct packed {
    attr_t attr;
    logic  done;
  } rendition_t;

  attr_t      attr_q;
  ext_step_e  ext_step;
  logic       ext_to_fg;
  param_t     red_raw;
  chan_t      green_sat;
  rendition_t rendition_q[$];

  function automatic chan_t sat_chan(param_t v);
    return (|v[PARAM_W-1:CHAN_W]) ? '1 : v[CHAN_W-1:0];
  endfunction

  function automatic rgb_t indexed_rgb(param_t idx);
    chan_t       n;
    int unsigned c;
    chan_t       g;
    n = sat_chan(idx);
    if (n < 16) return PAL16[n[3:0]];
    if (n <= 231) begin
      c = n - 16;
      return {CUBE_LEVEL[3'(c / 36)], CUBE_LEVEL[3'((c / 6) % 6)], CUBE_LEVEL[3'(c % 6)]};
    end
    g = chan_t'(8 + (n - 232) * 10);
    return {g, g, g};
  endfunction

  function automatic void store_color(logic to_fg, rgb_t rgb);
    if (to_fg) begin
      attr_q.fg_valid = 1'b1;
      attr_q.fg_rgb   = rgb;
    end else begin
      attr_q.bg_valid = 1'b1;
      attr_q.bg_rgb   = rgb;
    end
  endfunction

  function automatic void plain_code(param_t v, logic may_open);
    case (v)
      SGR_RESET:      attr_q = '0;
      SGR_BOLD:       attr_q.bold = 1'b1;
      SGR_ITALIC:     attr_q.italic = 1'b1;
      SGR_UNDERLINE:  attr_q.underline = 1'b1;
      SGR_REVERSE:    attr_q.reverse_video = 1'b1;
      SGR_STRIKE:     attr_q.strikethrough = 1'b1;
      SGR_NO_BOLD:    attr_q.bold = 1'b0;
      SGR_NO_ITALIC:  attr_q.italic = 1'b0;
      SGR_NO_UNDER:   attr_q.underline = 1'b0;
      SGR_NO_REVERSE: attr_q.reverse_video = 1'b0;
      SGR_NO_STRIKE:  attr_q.strikethrough = 1'b0;
      SGR_FG_DEFAULT: attr_q.fg_valid = 1'b0;
      SGR_BG_DEFAULT: attr_q.bg_valid = 1'b0;
      default: begin
        if (v >= SGR_FG_BASE && v <= SGR_FG_BASE + SGR_COLOR_SPAN)
          store_color(1'b1, PAL16[4'(v - SGR_FG_BASE)]);
        else if (v >= SGR_BG_BASE && v <= SGR_BG_BASE + SGR_COLOR_SPAN)
          store_color(1'b0, PAL16[4'(v - SGR_BG_BASE)]);
        else if (v >= SGR_FG_BRIGHT && v <= SGR_FG_BRIGHT + SGR_COLOR_SPAN)
          store_color(1'b1, PAL16[4'(v - SGR_FG_BRIGHT + 16'd8)]);
        else if (v >= SGR_BG_BRIGHT && v <= SGR_BG_BRIGHT + SGR_COLOR_SPAN)
          store_color(1'b0, PAL16[4'(v - SGR_BG_BRIGHT + 16'd8)]);
        else if ((v == SGR_FG_EXT || v == SGR_BG_EXT) && may_open) begin
          ext_step  = EXT_SEL;
          ext_to_fg = (v == SGR_FG_EXT);
        end
      end
    endcase
  endfunction

  // Advance the attribute state by one parameter and return what the block shows.
  function automatic rendition_t apply_param(param_t v, logic last, logic empty);
    ext_step_e  step;
    rendition_t r;
    step     = ext_step;
    ext_step = EXT_IDLE;
    if (empty) begin
      plain_code(SGR_RESET, 1'b0);
    end else begin
      case (step)
        EXT_SEL: begin
          if (v == SGR_SEL_INDEX && !last) ext_step = EXT_IDX;
          else if (v == SGR_SEL_RGB && !last) ext_step = EXT_RED;
          else plain_code(v, !last);
        end
        EXT_IDX: store_color(ext_to_fg, indexed_rgb(v));
        EXT_RED: begin
          if (last) begin
            plain_code(v, 1'b0);
          end else begin
            red_raw  = v;
            ext_step = EXT_GREEN;
          end
        end
        EXT_GREEN: begin
          // a list cut short after red and green replays both as plain codes
          if (last) begin
            plain_code(red_raw, 1'b0);
            plain_code(v, 1'b0);
          end else begin
            green_sat = sat_chan(v);
            ext_step  = EXT_BLUE;
          end
        end
        EXT_BLUE: store_color(ext_to_fg, {sat_chan(red_raw), green_sat, sat_chan(v)});
        default:  plain_code(v, !last);
      endcase
    end
    r.attr = attr_q;
    if (!r.attr.fg_valid) r.attr.fg_rgb = '0;
    if (!r.attr.bg_valid) r.attr.bg_rgb = '0;
    r.done = last | empty;
    return r;
  endfunction

  function automatic void check_field(string name, rgb_t exp_v, rgb_t act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    rendition_t want;
    if (!rst_ni) begin
      attr_q        = '0;
      ext_step      = EXT_IDLE;
      ext_to_fg     = 1'b0;
      red_raw       = '0;
      green_sat     = '0;
      rendition_q.delete();
      fail_count_o  = 0;
      outstanding_o = 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (rendition_q.size() == 0) begin
          $error("result with no request waiting");
          fail_count_o++;
        end else begin
          want = rendition_q.pop_front();
          check_field("bold", want.attr.bold, rsp_i.bold);
          check_field("italic", want.attr.italic, rsp_i.italic);
          check_field("underline", want.attr.underline, rsp_i.underline);
          check_field("reverse_video", want.attr.reverse_video, rsp_i.reverse_video);
          check_field("strikethrough", want.attr.strikethrough, rsp_i.strikethrough);
          check_field("fg_valid", want.attr.fg_valid, rsp_i.fg_valid);
          check_field("fg_rgb", want.attr.fg_rgb, rsp_i.fg_rgb);
          check_field("bg_valid", want.attr.bg_valid, rsp_i.bg_valid);
          check_field("bg_rgb", want.attr.bg_rgb, rsp_i.bg_rgb);
          check_field("sequence_done", want.done, rsp_i.sequence_done);
        end
      end
      if (req_i.valid && req_i.ready)
        rendition_q.push_back(apply_param(req_i.param_value, req_i.last_param,
                                          req_i.list_is_empty));
      outstanding_o = rendition_q.size();
    end
  end

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import sgr_ai_pkg::*;

  // Length of the random part, in requests.
  localparam int unsigned RANDOM_ITEMS = 450;
  // Cycles without any handshake before the run is declared hung.
  localparam int unsigned STALL_LIMIT  = 2000;
  // Length of the long receiver hold-off.
  localparam int unsigned HOLD_CYCLES  = 64;
  // Cycles to wait after the last result for a stray one.
  localparam int unsigned TAIL_CYCLES  = 8;

  localparam param_t FLAG_ON [5] = '{SGR_BOLD, SGR_ITALIC, SGR_UNDERLINE,
                                     SGR_REVERSE, SGR_STRIKE};
  localparam param_t FLAG_OFF [5] = '{SGR_NO_BOLD, SGR_NO_ITALIC, SGR_NO_UNDER,
                                      SGR_NO_REVERSE, SGR_NO_STRIKE};

  logic        clk_i;
  logic        rst_ni;
  int          fail_count;
  int          outstanding;
  logic        src_steady;
  logic        sink_steady;
  logic        hold_req;
  int unsigned sent;
  int unsigned idle_cycles = 0;
  param_t      seq_q[$];

  sgr_ai_req_if req_if ();
  sgr_ai_rsp_if rsp_if ();

  sgr_attribute_interpreter dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Watch both channels, predict every result and count mismatches.
  sgr_attribute_interpreter_checker attr_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req_if),
    .rsp_i         (rsp_if),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Receiver side: drop ready at random, hold it high during the steady
  // stretch, and hold it low for a long stretch once the sender asks.
  initial begin : sink_side
    int unsigned hold_left;
    hold_left    = 0;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (sink_steady) begin
        rsp_if.ready <= 1'b1;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= 20);
      end
    end
  end

  // Watchdog: end the run when nothing moves on either channel for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("** sgr_attribute_interpreter: FAILED **");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Offer one request and hold it until accepted. Called and left at a
  // falling edge; valid stays high into the next request unless a gap is drawn.
  task automatic push_param(param_t v, logic last, logic empty);
    if (!src_steady) begin
      while ($urandom_range(99) < 20) begin
        req_if.valid <= 1'b0;
        @(negedge clk_i);
      end
    end
    req_if.valid         <= 1'b1;
    req_if.param_value   <= v;
    req_if.last_param    <= last;
    req_if.list_is_empty <= empty;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    sent++;
  endtask

  task automatic push_seq();
    for (int i = 0; i < seq_q.size(); i++)
      push_param(seq_q[i], i == seq_q.size() - 1, 1'b0);
  endtask

  // Drop valid and wait until every predicted result has come back.
  task automatic drain();
    req_if.valid <= 1'b0;
    do @(negedge clk_i); while (outstanding != 0);
  endtask

  function automatic param_t pick_plain();
    case ($urandom_range(9))
      0:       return SGR_RESET;
      1:       return FLAG_ON[3'($urandom_range(4))];
      2:       return FLAG_OFF[3'($urandom_range(4))];
      3:       return SGR_FG_BASE + param_t'($urandom_range(SGR_COLOR_SPAN));
      4:       return SGR_BG_BASE + param_t'($urandom_range(SGR_COLOR_SPAN));
      5:       return SGR_FG_BRIGHT + param_t'($urandom_range(SGR_COLOR_SPAN));
      6:       return SGR_BG_BRIGHT + param_t'($urandom_range(SGR_COLOR_SPAN));
      7:       return $urandom_range(1) ? SGR_FG_DEFAULT : SGR_BG_DEFAULT;
      8:       return param_t'($urandom_range(110));
      default: return ($urandom_range(3) == 0) ? 16'hFFFF : param_t'($urandom);
    endcase
  endfunction

  // True-color channel: mostly in range, with the clamp and the extremes.
  function automatic param_t pick_channel();
    case ($urandom_range(3))
      0:       return param_t'($urandom_range(255));
      1:       return $urandom_range(1) ? 16'd255 : 16'd0;
      2:       return param_t'($urandom_range(256, 65535));
      default: return param_t'($urandom);
    endcase
  endfunction

  // Build one parameter list: mostly well-formed groups, some noise, and
  // now and then a list cut short, possibly inside an extended color.
  function automatic void build_random_seq();
    int unsigned groups;
    int unsigned k;
    int unsigned cut;
    param_t      ext;
    seq_q.delete();
    groups = $urandom_range(1, 4);
    repeat (groups) begin
      ext = $urandom_range(1) ? SGR_FG_EXT : SGR_BG_EXT;
      k   = $urandom_range(99);
      if (k < 45) begin
        seq_q.push_back(pick_plain());
      end else if (k < 65) begin
        seq_q.push_back(ext);
        seq_q.push_back(SGR_SEL_INDEX);
        seq_q.push_back(($urandom_range(9) < 7) ? param_t'($urandom_range(255))
                                                : param_t'($urandom_range(256, 65535)));
      end else if (k < 85) begin
        seq_q.push_back(ext);
        seq_q.push_back(SGR_SEL_RGB);
        seq_q.push_back(pick_channel());
        seq_q.push_back(pick_channel());
        seq_q.push_back(pick_channel());
      end else if (k < 93) begin
        seq_q.push_back(ext);
        seq_q.push_back(pick_plain());
      end else begin
        seq_q.push_back(param_t'($urandom));
      end
    end
    if ($urandom_range(99) < 20) begin
      cut = $urandom_range(1, seq_q.size());
      while (seq_q.size() > cut) void'(seq_q.pop_back());
    end
  endfunction

  initial begin : stimulus
    int unsigned start;
    logic        hold_done;
    logic        pause_done;
    logic        last;
    hold_done            = 1'b0;
    pause_done           = 1'b0;
    sent                 = 0;
    hold_req             = 1'b0;
    src_steady           = 1'b0;
    sink_steady          = 1'b0;
    rst_ni               = 1'b0;
    req_if.valid         = 1'b0;
    req_if.param_value   = '0;
    req_if.last_param    = 1'b0;
    req_if.list_is_empty = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // Empty list: the value must be ignored and everything cleared.
    push_param(16'hFFFF, 1'b1, 1'b1);
    // Set every flag, then the last normal fg and the last bright bg color.
    seq_q = '{SGR_BOLD, SGR_ITALIC, SGR_UNDERLINE, SGR_REVERSE, SGR_STRIKE,
              SGR_FG_BASE + SGR_COLOR_SPAN, SGR_BG_BRIGHT + SGR_COLOR_SPAN};
    push_seq();
    // Xterm index at full scale clamps to the top of the gray ramp.
    seq_q = '{SGR_FG_EXT, SGR_SEL_INDEX, 16'hFFFF};
    push_seq();
    // True color with a clamped red, a zero green and a full blue.
    seq_q = '{SGR_BG_EXT, SGR_SEL_RGB, 16'd300, 16'd0, 16'd255};
    push_seq();
    // True color cut after red and green: both replay as plain codes.
    seq_q = '{SGR_FG_EXT, SGR_SEL_RGB, SGR_FG_BRIGHT + SGR_COLOR_SPAN, SGR_BOLD};
    push_seq();
    // Empty list in the middle of an extended color drops it.
    push_param(SGR_BG_EXT, 1'b0, 1'b0);
    push_param(SGR_SEL_INDEX, 1'b0, 1'b0);
    push_param('0, 1'b0, 1'b1);
    // A selector other than index or rgb is taken as a plain code.
    seq_q = '{SGR_FG_EXT, SGR_BG_BASE, SGR_NO_BOLD, SGR_RESET};
    push_seq();
    // A final 48 opens nothing.
    push_param(SGR_BG_EXT, 1'b1, 1'b0);

    start = sent;
    while (sent - start < RANDOM_ITEMS) begin
      // No gaps on either side for a stretch in the middle.
      src_steady  = (sent - start >= 250) && (sent - start < 350);
      sink_steady = src_steady;
      // Let the receiver hold off while requests keep coming, to fill the pipe.
      if (!hold_done && sent - start >= 100) begin
        hold_done = 1'b1;
        hold_req  = 1'b1;
      end
      // Pause once until the pipe is empty.
      if (!pause_done && sent - start >= 200) begin
        pause_done = 1'b1;
        drain();
      end
      if ($urandom_range(99) < 4) begin
        push_param(param_t'($urandom), 1'($urandom_range(1)), 1'b1);
      end else begin
        build_random_seq();
        for (int i = 0; i < seq_q.size(); i++) begin
          last = (i == seq_q.size() - 1);
          if ($urandom_range(99) < 4) push_param(param_t'($urandom), last, 1'b1);
          else push_param(seq_q[i], last, 1'b0);
        end
      end
    end
    src_steady  = 1'b0;
    sink_steady = 1'b0;

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0)
      $display("** sgr_attribute_interpreter: PASSED **");
    else
      $display("** sgr_attribute_interpreter: FAILED **");
    $finish;
  end

endmodule
